// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle -> consequent holds in the same cycle.
`define TIDD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tidd assertion failed");

// Antecedent holds in a cycle -> consequent holds in the next cycle.
`define TIDD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tidd assertion failed");

`endif

// ===== src/tidd_pkg.sv =====
// Types and constants of the time interval delta decoder.
package tidd_pkg;

	typedef enum logic [1:0] {
		STAGE_HEADER,
		STAGE_HEAD,
		STAGE_BODY,
		STAGE_ESCAPE
	} stage_t;

	localparam logic [1:0] STATUS_CONT = 2'd0;
	localparam logic [1:0] STATUS_OK   = 2'd1;
	localparam logic [1:0] STATUS_ERR  = 2'd2;

	localparam logic [2:0]  HEADER_BYTES = 3'd6;
	localparam logic [2:0]  ESCAPE_BYTES = 3'd6;
	localparam logic [47:0] ESCAPE_VALUE = 48'h00_3f_ff_ff_ff_ff;

	localparam int TDATA_W = 104;
	localparam int TUSER_W = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic               period_valid;
		logic        [47:0] period_start;
		logic signed [48:0] period_duration;
		logic        [1:0]  frame_status;
	} result_t;

endpackage

// ===== src/tidd_in_stage.sv =====
// Input register: captures one byte transaction from the slave side.
module tidd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tidd_pkg::in_item_t s_item,
	input  logic              go,
	output logic              valid_s1,
	output tidd_pkg::in_item_t item_s1
);
	import tidd_pkg::*;

	// the stage empties in the cycle the parser consumes it
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_item;
		end
	end

endmodule

// ===== src/tidd_parser.sv =====
// Byte parser: header, field assembly, escape handling and interval build.
module tidd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  tidd_pkg::in_item_t item_s1,
	output logic               res_valid,
	output tidd_pkg::result_t  res
);
	import tidd_pkg::*;

	stage_t      stage_q, stage_n;
	logic [2:0]  remain_q, remain_n;
	logic [47:0] field_q, field_n;
	// base_q: running time plus pending delta; base_m1_q: base_q - 1
	logic [47:0] base_q, base_n;
	logic [47:0] base_m1_q;
	logic        fix_q, fix_n;
	logic        expect_q, expect_n;

	logic [47:0] shifted;
	logic [47:0] sum;
	logic        done;
	logic        emit;
	logic [7:0]  b;

	assign b       = item_s1.data_byte;
	assign shifted = {field_q[39:0], b};
	// duration end: start + value - 1; delta end: running time + delta
	assign sum     = (expect_q ? base_m1_q : base_q) + shifted;

	always_comb begin
		stage_n  = stage_q;
		remain_n = remain_q;
		field_n  = field_q;
		base_n   = base_q;
		fix_n    = 1'b0;
		expect_n = expect_q;
		done     = 1'b0;
		emit     = 1'b0;
		res      = '0;

		case (stage_q)
			STAGE_HEADER: begin
				field_n  = shifted;
				remain_n = remain_q - 3'd1;
				if (remain_n == 3'd0) begin
					base_n  = shifted;
					fix_n   = 1'b1;
					field_n = '0;
					stage_n = STAGE_HEAD;
				end
			end
			STAGE_HEAD: begin
				field_n  = {42'd0, b[5:0]};
				remain_n = 3'd1 + {1'b0, b[7:6]};
				stage_n  = STAGE_BODY;
			end
			STAGE_BODY: begin
				field_n  = shifted;
				remain_n = remain_q - 3'd1;
				if (remain_n == 3'd0) begin
					if (shifted == ESCAPE_VALUE) begin
						field_n  = '0;
						remain_n = ESCAPE_BYTES;
						stage_n  = STAGE_ESCAPE;
					end else begin
						done = 1'b1;
					end
				end
			end
			default: begin
				field_n  = shifted;
				remain_n = remain_q - 3'd1;
				if (remain_n == 3'd0) begin
					done = 1'b1;
				end
			end
		endcase

		if (done) begin
			if (expect_q) begin
				emit                = 1'b1;
				res.period_valid    = 1'b1;
				res.period_start    = base_q;
				res.period_duration = $signed({1'b0, shifted} - 49'd1);
				expect_n            = 1'b0;
			end else begin
				expect_n = 1'b1;
			end
			base_n  = sum;
			fix_n   = 1'b1;
			field_n = '0;
			stage_n = STAGE_HEAD;
		end

		res_valid = emit || item_s1.end_of_buffer;
		if (item_s1.end_of_buffer) begin
			res.frame_status = (stage_n != STAGE_HEADER && !expect_n) ? STATUS_OK : STATUS_ERR;
			stage_n  = STAGE_HEADER;
			remain_n = HEADER_BYTES;
			field_n  = '0;
			base_n   = '0;
			fix_n    = 1'b0;
			expect_n = 1'b1;
		end else begin
			res.frame_status = STATUS_CONT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= STAGE_HEADER;
			remain_q <= HEADER_BYTES;
			field_q  <= '0;
			base_q   <= '0;
			fix_q    <= 1'b0;
			expect_q <= 1'b1;
		end else if (go) begin
			stage_q  <= stage_n;
			remain_q <= remain_n;
			field_q  <= field_n;
			base_q   <= base_n;
			fix_q    <= fix_n;
			expect_q <= expect_n;
		end else begin
			fix_q <= 1'b0;
		end
	end

	// base - 1 settles in the cycle after base moves; the next field end
	// is at least two bytes away
	always_ff @(posedge clk) begin
		if (fix_q) begin
			base_m1_q <= base_q - 48'd1;
		end
	end

endmodule

// ===== src/tidd_out_reg.sv =====
// Result register on the master side.
module tidd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic              res_valid,
	input  tidd_pkg::result_t res,
	output logic              out_free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output tidd_pkg::result_t res_q
);
	import tidd_pkg::*;

	logic load;

	assign out_free = !m_tvalid || m_tready;
	assign load     = go && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ===== src/time_interval_delta_decoder.sv =====
// Top level of the time interval delta decoder.
//
// Slave side takes one buffer byte per transaction in s_tdata; s_tlast marks
// the last byte of a buffer. Master side gives one result transaction for each
// byte that completes an interval, ends a buffer, or both.
// m_tuser[0] says the transaction carries an interval, m_tuser[2:1] is the
// buffer status (continues, ended ok, ended with error).
// A byte passes the input register, then the result register, before its
// result shows at m_tvalid.
// Throughput: one byte per cycle while the output register is free, set by
// the single parse pass between the input register and the result register;
// the running-time adder and the field shift both close in that pass.
// When the receiver stalls, the result is held in the output register and
// one more byte is taken into the input register; s_tready drops then.
// Reset clears the valid bits of both registers and returns the parser to the header stage;
// the end of each buffer does the same for the parser state.
module time_interval_delta_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // [7:0] data_byte
	input  logic                          s_tlast,  // end_of_buffer
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [47:0] period_start, [96:48] period_duration, [103:97] zero
	output logic [tidd_pkg::TDATA_W-1:0]  m_tdata,
	// [0] period_valid, [2:1] frame_status
	output logic [tidd_pkg::TUSER_W-1:0]  m_tuser
);
	import tidd_pkg::*;

	in_item_t s_item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     go;
	logic     out_free;
	logic     res_valid;
	result_t  res;
	result_t  res_q;

	assign s_item.data_byte     = s_tdata;
	assign s_item.end_of_buffer = s_tlast;
	assign go = valid_s1 && out_free;

	tidd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.go       (go),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tidd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	tidd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_q     (res_q)
	);

	assign m_tdata = {7'd0, res_q.period_duration, res_q.period_start};
	assign m_tuser = {res_q.frame_status, res_q.period_valid};

endmodule

// ===== src/tidd_checker.sv =====
// Port-level checker for the time interval delta decoder, with its bind.
`include "assert_macros.svh"

module tidd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [7:0]                   s_tdata,
	input logic                         s_tlast,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [tidd_pkg::TDATA_W-1:0] m_tdata,
	input logic [tidd_pkg::TUSER_W-1:0] m_tuser
);
	import tidd_pkg::*;

	// stalled result transaction holds
	`TIDD_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// a result either carries an interval or closes a buffer
	`TIDD_ASSERT_IMP(a_reason, clk, arst_n, m_tvalid, m_tuser[0] || (m_tuser[2:1] != STATUS_CONT))
	// results without an interval carry zero start and duration
	`TIDD_ASSERT_IMP(a_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == '0)
	// a negative duration can only be the infinite marker
	`TIDD_ASSERT_IMP(a_dur, clk, arst_n, m_tvalid && m_tdata[96], m_tdata[96:48] == '1)
	// status code stays within the defined set
	`TIDD_ASSERT_IMP(a_status, clk, arst_n, m_tvalid, m_tuser[2:1] != 2'd3)

endmodule

bind time_interval_delta_decoder tidd_checker u_checker (.*);

// ===== verif/interval_result_checker.sv =====
// Checker for the time interval delta decoder: predicts results and compares them.
`timescale 1ns / 1ps

module interval_result_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [7:0] data_byte
	input  logic                         s_tlast,  // end_of_buffer
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	// [47:0] period_start, [96:48] period_duration, [103:97] zero
	input  logic [tidd_pkg::TDATA_W-1:0] m_tdata,
	// [0] period_valid, [2:1] frame_status
	input  logic [tidd_pkg::TUSER_W-1:0] m_tuser,
	output int                           pending,
	output int                           failures
);
	import tidd_pkg::*;

	localparam int MAX_REPORTS = 100;

	// decoder state as the byte stream has left it
	stage_t      stage;
	logic [2:0]  left;
	logic [47:0] acc;
	logic [47:0] run_time;
	logic [47:0] delta;
	logic        want_dur;

	result_t due_intervals[$];
	result_t want;
	int      fails;

	function automatic void clear_parser();
		stage = STAGE_HEADER;
		left = HEADER_BYTES;
		acc = '0;
		run_time = '0;
		delta = '0;
		want_dur = 1'b1;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		logic        done;
		logic        emit;
		logic [47:0] start_ms;
		logic [48:0] dur_ms;
		result_t     r;
		done = 1'b0;
		emit = 1'b0;
		start_ms = '0;
		dur_ms = '0;
		case (stage)
			STAGE_HEADER: begin
				acc = {acc[39:0], b};
				left = left - 3'd1;
				if (left == 3'd0) begin
					run_time = acc;
					acc = '0;
					stage = STAGE_HEAD;
				end
			end
			STAGE_HEAD: begin
				acc = {42'd0, b[5:0]};
				left = 3'd1 + {1'b0, b[7:6]};
				stage = STAGE_BODY;
			end
			STAGE_BODY: begin
				acc = {acc[39:0], b};
				left = left - 3'd1;
				if (left == 3'd0) begin
					if (acc == ESCAPE_VALUE) begin
						acc = '0;
						left = ESCAPE_BYTES;
						stage = STAGE_ESCAPE;
					end else begin
						done = 1'b1;
					end
				end
			end
			default: begin
				acc = {acc[39:0], b};
				left = left - 3'd1;
				if (left == 3'd0)
					done = 1'b1;
			end
		endcase

		if (done) begin
			if (want_dur) begin
				start_ms = run_time + delta;
				// field holds duration+1; zero wraps to -1 (infinite)
				dur_ms = {1'b0, acc} - 49'd1;
				run_time = start_ms + acc - 48'd1;
				delta = '0;
				want_dur = 1'b0;
				emit = 1'b1;
			end else begin
				delta = acc;
				want_dur = 1'b1;
			end
			acc = '0;
			stage = STAGE_HEAD;
		end

		if (emit || last) begin
			r.period_valid = emit;
			r.period_start = start_ms;
			r.period_duration = dur_ms;
			if (last)
				r.frame_status = (stage != STAGE_HEADER && !want_dur) ? STATUS_OK : STATUS_ERR;
			else
				r.frame_status = STATUS_CONT;
			due_intervals = {due_intervals, r};
			if (last)
				clear_parser();
		end
	endfunction

	function automatic int field_bad(input string name, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			if (fails < MAX_REPORTS)
				$error("%s: expected %0d, actual %0d", name, exp_v, got_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			due_intervals.delete();
			fails = 0;
			pending <= 0;
			failures <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_intervals.size() == 0) begin
					if (fails < MAX_REPORTS)
						$error("unexpected result transaction: tuser %h tdata %h", m_tuser, m_tdata);
					fails++;
				end else begin
					want = due_intervals.pop_front();
					fails += field_bad("period_valid", want.period_valid, m_tuser[0]);
					fails += field_bad("frame_status", want.frame_status, m_tuser[2:1]);
					fails += field_bad("period_start", want.period_start, m_tdata[47:0]);
					fails += field_bad("period_duration", longint'(want.period_duration),
						longint'($signed(m_tdata[96:48])));
					fails += field_bad("tdata padding", 0, m_tdata[103:97]);
				end
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			pending <= due_intervals.size();
			failures <= fails;
		end
	end

endmodule

// ===== verif/tb_time_interval_delta_decoder.sv =====
// Testbench top for the time interval delta decoder: stimulus and verdict.
`timescale 1ns / 1ps

module tb_time_interval_delta_decoder;
	import tidd_pkg::*;

	localparam int          RANDOM_BYTES = 1100;
	localparam int          HOLD_CYCLES = 400;
	localparam int          IDLE_LIMIT = 5000;
	localparam int          TAIL_CYCLES = 16;
	localparam logic [39:0] ESCAPE_MARK = 40'hff_ffff_ffff;  // 5-byte field of all ones

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;
	logic [TUSER_W-1:0]  m_tuser;

	int   pending;
	int   failures;
	int   hold_requests;
	int   burst_left;
	int   bytes_sent;
	logic [7:0] frame_bytes[$];

	always #4 clk = ~clk;

	time_interval_delta_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	interval_result_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.pending  (pending),
		.failures (failures)
	);

	function automatic logic [47:0] pick_ms_value();
		case ($urandom_range(0, 7))
			0: return 48'd0;
			1: return '1;
			2: return 48'($urandom_range(0, 255));
			3: return 48'($urandom_range(0, 65535));
			4: return {16'd0, 32'($urandom)};
			// around the escape value
			5: return ESCAPE_VALUE + 48'($urandom_range(0, 2)) - 48'd1;
			default: return {16'($urandom), 32'($urandom)};
		endcase
	endfunction

	task automatic add_byte(input logic [7:0] v);
		frame_bytes = {frame_bytes, v};
	endtask

	task automatic put_be(input logic [47:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			add_byte(v[8*i +: 8]);
	endtask

	task automatic put_field(input logic [47:0] v);
		int min_len;
		int len;
		if (v < 48'h4000)
			min_len = 2;
		else if (v < 48'h40_0000)
			min_len = 3;
		else if (v < 48'h4000_0000)
			min_len = 4;
		else if (v < ESCAPE_VALUE)
			min_len = 5;
		else
			min_len = 6;
		// length 6 stands for the escaped form
		len = (min_len == 6 || $urandom_range(0, 9) == 0) ? 6 : $urandom_range(min_len, 5);
		if (len == 6) begin
			put_be({8'd0, ESCAPE_MARK}, 5);
			put_be(v, 6);
		end else begin
			add_byte({2'(len - 2), 6'(v >> (8 * (len - 1)))});
			put_be(v, len - 1);
		end
	endtask

	task automatic trim_frame(input int keep);
		while (frame_bytes.size() > keep)
			void'(frame_bytes.pop_back());
	endtask

	task automatic build_frame();
		int kind;
		int count;
		int cut_from;
		int tail;
		frame_bytes.delete();
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			count = $urandom_range(1, 20);
			repeat (count)
				add_byte(8'($urandom));
		end else begin
			put_be(pick_ms_value(), 6);
			count = $urandom_range(0, 6);
			for (int i = 0; i < count; i++) begin
				if (i > 0)
					put_field(pick_ms_value());
				put_field(pick_ms_value());
			end
			// optional trailing delta, then duration, cut after any of their bytes
			cut_from = frame_bytes.size();
			tail = $urandom_range(0, 3);
			if (tail >= 1)
				put_field(pick_ms_value());
			if (tail == 3)
				put_field(pick_ms_value());
			if (tail != 0)
				trim_frame($urandom_range(cut_from + 1, frame_bytes.size()));
			if (kind <= 2)
				trim_frame($urandom_range(1, frame_bytes.size()));
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		burst_left = 0;
	endtask

	// receiver: own stall pattern, plus a long hold-off on request
	initial begin
		int mode;
		int span;
		int tick;
		int holds_served;
		m_tready <= 1'b0;
		mode = 0;
		span = 0;
		tick = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(16, 128);
				end
				span--;
				tick++;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (tick % 3 == 0);
				endcase
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic hold_asked;
		logic drained;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		hold_requests <= 0;
		burst_left = 0;
		bytes_sent = 0;
		hold_asked = 1'b0;
		drained = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// max base time, infinite duration sets the running time to start - 1; ends ok
		frame_bytes.delete();
		put_be('1, 6);
		put_be(48'd0, 2);
		send_frame();
		// header cut short
		frame_bytes.delete();
		put_be(48'd0, 1);
		send_frame();
		// escaped duration of full scale, interval and status in one transaction
		frame_bytes.delete();
		put_be(48'd0, 6);
		put_be({8'd0, ESCAPE_MARK}, 5);
		put_be('1, 6);
		send_frame();

		while (bytes_sent < RANDOM_BYTES) begin
			build_frame();
			send_frame();
			if (!hold_asked && bytes_sent > RANDOM_BYTES / 3) begin
				hold_requests <= hold_requests + 1;
				hold_asked = 1'b1;
			end
			if (!drained && bytes_sent > 2 * RANDOM_BYTES / 3) begin
				drain_results();
				drained = 1'b1;
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
